[hw/rtl/sss_pkg.sv]
// Shared types and constants for the sprite scan-line search block.
// No dependencies; every other file imports this package.
package sss_pkg;

  localparam int TableEntriesDef = 40;
  localparam int LineLimitDef    = 10;

  localparam int YOffset     = 16;
  localparam int ShortHeight = 8;
  localparam int TallHeight  = 16;

  localparam int CoordW   = 8;
  localparam int PaddrW   = 3;
  localparam int PdataW   = 32;

  // Register index of the sprite-height control.
  localparam logic RegTallSprites = 1'b0;

  typedef enum logic [1:0] {
    ST_SCAN = 2'b01,
    ST_EMIT = 2'b10
  } sss_state_e;

  // Control handed to every cell of the sorted chain.
  typedef struct packed {
    logic ins;    // insert the new entry in sorted place
    logic shift;  // move every entry one cell toward the head
  } sss_ctrl_t;

endpackage

[hw/rtl/sss_if.sv]
// Valid/ready channel interfaces for the sprite scan-line search block.
// Depends on sss_pkg for the coordinate width.
interface sss_in_if import sss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] sprite_y;
  logic [CoordW-1:0] sprite_x;
  logic [CoordW-1:0] scan_line;
  logic              last_entry;

  modport source (output valid, sprite_y, sprite_x, scan_line, last_entry, input ready);
  modport sink   (input valid, sprite_y, sprite_x, scan_line, last_entry, output ready);
endinterface

interface sss_out_if import sss_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int CNT_W = 4
) ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  entry_index;
  logic [CoordW-1:0] entry_x;
  logic [CNT_W-1:0]  found_count;
  logic              valid_res;
  logic              last_result;

  modport source (output valid, entry_index, entry_x, found_count, valid_res, last_result,
                  input ready);
  modport sink   (input valid, entry_index, entry_x, found_count, valid_res, last_result,
                  output ready);
endinterface

[hw/rtl/sprite_scanline_search_core.sv]
// Flow: an entry request is taken every cycle while scanning; the list appears the cycle
// after the request marked last_entry, then one result per cycle while the sink is ready.
// No entry is taken while results remain. The x-sorted cell chain takes each selected
// entry into its sorted place as the request is accepted and drains from its head cell.
// Reset: asynchronous, active low; clears the chain valid bits, counters, state and the
// tall_sprites register. No clearing pass is needed.
module sprite_scanline_search_core import sss_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int LINE_LIMIT    = LineLimitDef,
  parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  parameter int CNT_W = $clog2(LINE_LIMIT + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sss_in_if.sink            in_i,
  sss_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int CtrW = $clog2(TABLE_ENTRIES + 1);

  // ---------------------------------------------------------------------------
  // Configuration register: one bit, address 0.
  // ---------------------------------------------------------------------------
  logic tall_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PaddrW-1] == RegTallSprites);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tall_q <= 1'b0;
    end else if (cfg_wr) begin
      tall_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[PaddrW-1] == RegTallSprites) ? {{(PdataW-1){1'b0}}, tall_q}
                                                      : '0;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  sss_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;    // entries held; frozen while emitting
  logic [CNT_W-1:0] rem_q, rem_d;        // results still to deliver
  logic [CtrW-1:0]  ctr_q, ctr_d;        // table index of the next entry

  logic in_acc, out_acc;
  logic hit, ins;
  logic [CoordW:0] target, y_top;
  sss_ctrl_t ctrl;

  assign in_i.ready = (state_q == ST_SCAN);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  // Line test: line+16 >= y and line+16 < y+height, all at 9 bits so nothing wraps.
  assign target = {1'b0, in_i.scan_line} + (CoordW+1)'(YOffset);
  assign y_top  = {1'b0, in_i.sprite_y}
                + (tall_q ? (CoordW+1)'(TallHeight) : (CoordW+1)'(ShortHeight));
  assign hit    = (target >= {1'b0, in_i.sprite_y}) && (target < y_top);

  // Drop selections past the end of the table or once the list is full.
  assign ins = in_acc && hit && (ctr_q < CtrW'(TABLE_ENTRIES))
            && (count_q < CNT_W'(LINE_LIMIT));

  assign ctrl.ins   = ins;
  assign ctrl.shift = out_acc;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rem_d   = rem_q;
    ctr_d   = ctr_q;
    case (state_q)
      ST_SCAN: begin
        if (in_acc) begin
          count_d = count_q + CNT_W'(ins);
          if (ctr_q < CtrW'(TABLE_ENTRIES)) begin
            ctr_d = ctr_q + CtrW'(1);
          end
          if (in_i.last_entry) begin
            // Start over on the next line; hand the list to the output side.
            ctr_d   = '0;
            rem_d   = count_d;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (rem_q <= CNT_W'(1)) begin
            count_d = '0;
            rem_d   = '0;
            state_d = ST_SCAN;
          end else begin
            rem_d = rem_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SCAN;
      count_q <= '0;
      rem_q   <= '0;
      ctr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      ctr_q   <= ctr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sorted chain: cell 0 holds the largest x; equal x keeps the later index first
  // because a new entry lands ahead of any entry with the same x.
  // ---------------------------------------------------------------------------
  logic [LINE_LIMIT-1:0]  c_keep, c_valid;
  logic [IDX_W-1:0]       c_idx [LINE_LIMIT];
  logic [CoordW-1:0]      c_x   [LINE_LIMIT];
  logic [IDX_W-1:0]       new_idx;

  assign new_idx = ctr_q[IDX_W-1:0];

  for (genvar k = 0; k < LINE_LIMIT; k++) begin : g_cell
    logic              p_keep, p_valid, n_valid;
    logic [IDX_W-1:0]  p_idx, n_idx;
    logic [CoordW-1:0] p_x, n_x;

    if (k == 0) begin : g_head
      assign p_keep  = 1'b1;
      assign p_valid = 1'b0;
      assign p_idx   = new_idx;
      assign p_x     = in_i.sprite_x;
    end else begin : g_body
      assign p_keep  = c_keep[k-1];
      assign p_valid = c_valid[k-1];
      assign p_idx   = c_idx[k-1];
      assign p_x     = c_x[k-1];
    end

    if (k == LINE_LIMIT - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_idx   = c_idx[k];
      assign n_x     = c_x[k];
    end else begin : g_mid
      assign n_valid = c_valid[k+1];
      assign n_idx   = c_idx[k+1];
      assign n_x     = c_x[k+1];
    end

    sss_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_idx_i    (new_idx),
      .new_x_i      (in_i.sprite_x),
      .prev_keep_i  (p_keep),
      .prev_valid_i (p_valid),
      .prev_idx_i   (p_idx),
      .prev_x_i     (p_x),
      .next_valid_i (n_valid),
      .next_idx_i   (n_idx),
      .next_x_i     (n_x),
      .keep_o       (c_keep[k]),
      .valid_o      (c_valid[k]),
      .idx_o        (c_idx[k]),
      .x_o          (c_x[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Result side: all fields come straight from registers (head cell, counters).
  // An empty line yields one zero result marked last.
  // ---------------------------------------------------------------------------
  logic empty;
  assign empty = (count_q == '0);

  assign out_o.valid       = (state_q == ST_EMIT);
  assign out_o.entry_index = empty ? '0 : c_idx[0];
  assign out_o.entry_x     = empty ? '0 : c_x[0];
  assign out_o.found_count = count_q;
  assign out_o.valid_res   = !empty;
  assign out_o.last_result = empty || (rem_q == CNT_W'(1));

`ifndef SYNTHESIS
  // Never take an entry while a list is still draining.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("entry request taken while results pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LINE_LIMIT))
    else $error("held count beyond line limit");

  // A nonempty list always has its next result in the head cell.
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !empty) |-> c_valid[0])
    else $error("head cell empty while results remain");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_result) |=> (in_i.ready && count_q == '0))
    else $error("search did not restart after final result");

  // The chain drains completely with the final result.
  a_chain_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_result) |=> !c_valid[0])
    else $error("chain not empty after final result");
`endif

endmodule

[hw/rtl/sss_cell.sv]
// One cell of the x-sorted sprite chain: holds one selected entry.
// Depends on sss_pkg (control struct, coordinate width).
module sss_cell import sss_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sss_ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0]  new_idx_i,
  input  logic [CoordW-1:0] new_x_i,
  input  logic              prev_keep_i,
  input  logic              prev_valid_i,
  input  logic [IDX_W-1:0]  prev_idx_i,
  input  logic [CoordW-1:0] prev_x_i,
  input  logic              next_valid_i,
  input  logic [IDX_W-1:0]  next_idx_i,
  input  logic [CoordW-1:0] next_x_i,
  output logic              keep_o,
  output logic              valid_o,
  output logic [IDX_W-1:0]  idx_o,
  output logic [CoordW-1:0] x_o
);

  logic              valid_q, valid_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CoordW-1:0] x_q, x_d;

  // Hold when this entry sorts strictly ahead of the new one.
  assign keep_o = valid_q && (x_q > new_x_i);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    x_d     = x_q;
    if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      idx_d   = next_idx_i;
      x_d     = next_x_i;
    end else if (ctrl_i.ins && !keep_o) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        idx_d   = new_idx_i;
        x_d     = new_x_i;
      end else begin
        valid_d = prev_valid_i;
        idx_d   = prev_idx_i;
        x_d     = prev_x_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    x_q   <= x_d;
  end

  assign valid_o = valid_q;
  assign idx_o   = idx_q;
  assign x_o     = x_q;

endmodule

[tb/sv/sprite_scanline_search_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sprite_scanline_search_core: directed table, then random searches.
// Depends on sss_pkg and the sss_in_if / sss_out_if channel interfaces.
module sprite_scanline_search_core_tb;
  import sss_pkg::*;

  localparam int ItemGoal   = 222;
  localparam int StallLimit = 1000;
  localparam int ShowLimit  = 10;

  // One search result as it leaves the block.
  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] x;
    logic [3:0] cnt;
    logic       vld;
    logic       lst;
  } sprite_hit_t;

  // Directed row: height setting, entry fields, and an optional hand-typed single result.
  typedef struct packed {
    logic       tall;
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] ln;
    logic       lst;
    logic       typed;
    logic [5:0] r_idx;
    logic [7:0] r_x;
    logic [3:0] r_cnt;
    logic       r_vld;
  } scan_row_t;

  logic clk_i;
  logic rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  sss_in_if                              in_ch ();
  sss_out_if #(.IDX_W(6), .CNT_W(4))     out_ch ();

  sprite_scanline_search_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: the x-sorted held list, its fill, the table index of the next entry,
  // and the shadow of the height register.
  logic [5:0]  held_idx [LineLimitDef];
  logic [7:0]  held_x   [LineLimitDef];
  int          held_n;
  int          next_idx;
  logic        tall_cfg;

  sprite_hit_t pending_hits [$];

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int idle_cycles;
  int n_entries;
  int n_results;
  int n_searches;
  int n_full;
  int n_saturated;

  // Directed table: after-reset empty search, field extremes, window edges for both heights,
  // equal-x ordering and a search that overflows the ten-entry list.
  scan_row_t dir_rows [24] = '{
    '{1'b0,   8'd0,   8'd0,   8'd0, 1'b1, 1'b1, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b0,  8'd16, 8'd255,   8'd0, 1'b1, 1'b1, 6'd0, 8'd255, 4'd1, 1'b1},
    '{1'b0, 8'd255,   8'd0, 8'd153, 1'b1, 1'b1, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b0, 8'd169, 8'd128, 8'd153, 1'b1, 1'b1, 6'd0, 8'd128, 4'd1, 1'b1},
    '{1'b0,   8'd8,  8'd10,   8'd0, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b0,   8'd9,  8'd10,   8'd0, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b0,  8'd17,  8'd10,   8'd0, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b0,  8'd16,  8'd10,   8'd0, 1'b1, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1,   8'd0,   8'd5,   8'd0, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1,   8'd1, 8'd200,   8'd0, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1,  8'd16,   8'd0,   8'd0, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd154,   8'd7, 8'd153, 1'b1, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd101,   8'd0, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd116, 8'd255, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd110,  8'd37, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd105,  8'd37, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd101,  8'd90, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd116,   8'd1, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd108, 8'd254, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd112,  8'd37, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd103, 8'd128, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd115,  8'd64, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd102, 8'd200, 8'd100, 1'b0, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0},
    '{1'b1, 8'd111,   8'd3, 8'd100, 1'b1, 1'b0, 6'd0,   8'd0, 4'd0, 1'b0}
  };

  // Free-running clock, 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Advance the predictor by one accepted entry request; on the last entry of a search,
  // queue the expected list (or the single empty result) and start the next search over.
  task automatic predict_entry(input logic [7:0] y, input logic [7:0] x,
                               input logic [7:0] ln, input logic lst);
    int tgt;
    int h;
    int pos;
    begin
      n_entries++;
      if (next_idx < TableEntriesDef) begin
        h   = tall_cfg ? TallHeight : ShortHeight;
        tgt = int'(ln) + YOffset;
        if (tgt >= int'(y) && tgt < int'(y) + h && held_n < LineLimitDef) begin
          // Equal x lands ahead of older entries, which gives descending index on ties.
          pos = 0;
          while (pos < held_n && held_x[pos] > x) pos++;
          for (int k = held_n; k > pos; k--) begin
            held_idx[k] = held_idx[k-1];
            held_x[k]   = held_x[k-1];
          end
          held_idx[pos] = 6'(next_idx);
          held_x[pos]   = x;
          held_n++;
        end
        next_idx++;
      end else begin
        n_saturated++;
      end
      if (lst) begin
        n_searches++;
        if (held_n == LineLimitDef) n_full++;
        if (held_n == 0) begin
          pending_hits.push_back('{6'd0, 8'd0, 4'd0, 1'b0, 1'b1});
        end else begin
          for (int k = 0; k < held_n; k++) begin
            pending_hits.push_back('{held_idx[k], held_x[k], 4'(held_n), 1'b1,
                                     (k == held_n - 1)});
          end
        end
        held_n   = 0;
        next_idx = 0;
      end
    end
  endtask

  // Offer one entry request with a random lead-in gap; valid stays high on return so that a
  // back-to-back request needs no drop. Called and returns at a falling edge.
  task automatic send_entry(input logic [7:0] y, input logic [7:0] x, input logic [7:0] ln,
                            input logic lst, input logic typed, input sprite_hit_t typed_hit);
    begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_ch.valid = 1'b0;
        @(negedge clk_i);
      end
      in_ch.valid      = 1'b1;
      in_ch.sprite_y   = y;
      in_ch.sprite_x   = x;
      in_ch.scan_line  = ln;
      in_ch.last_entry = lst;
      do @(posedge clk_i); while (!in_ch.ready);
      predict_entry(y, x, ln, lst);
      // A typed row yields exactly one result: hold the hand-written value instead.
      if (typed) begin
        void'(pending_hits.pop_back());
        pending_hits.push_back(typed_hit);
      end
      @(negedge clk_i);
    end
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic wait_idle();
    begin
      in_ch.valid = 1'b0;
      while (pending_hits.size() != 0) @(negedge clk_i);
    end
  endtask

  // Write the height register over the APB port while idle, then read it back.
  task automatic set_tall(input logic value);
    begin
      wait_idle();
      // Entries without a result may still be in flight inside the chain: wait before the write.
      repeat (4) @(negedge clk_i);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = PaddrW'(4 * int'(RegTallSprites));
      pwdata  = PdataW'(value);
      @(negedge clk_i);
      penable = 1'b1;
      do @(posedge clk_i); while (!pready);
      tall_cfg = value;
      @(negedge clk_i);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clk_i);
      penable = 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== PdataW'(value)) begin
        err_count++;
        if (err_count <= ShowLimit)
          $display("[%0t] register readback: expected %0h, got %0h", $realtime, value, prdata);
      end
      @(negedge clk_i);
      psel    = 1'b0;
      penable = 1'b0;
    end
  endtask

  // Receiver stall pattern, redrawn every falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check every accepted result against the oldest expectation; count quiet cycles.
  always @(posedge clk_i) begin
    sprite_hit_t got;
    sprite_hit_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.entry_index, out_ch.entry_x, out_ch.found_count, out_ch.valid_res,
              out_ch.last_result};
      n_results++;
      if (pending_hits.size() == 0) begin
        err_count++;
        if (err_count <= ShowLimit)
          $display("[%0t] unexpected result: idx %0d x %0d cnt %0d vld %0b last %0b",
                   $realtime, got.idx, got.x, got.cnt, got.vld, got.lst);
      end else begin
        want = pending_hits.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= ShowLimit) begin
            $write("[%0t] mismatch: idx %0d/%0d x %0d/%0d cnt %0d/%0d ", $realtime,
                   want.idx, got.idx, want.x, got.x, want.cnt, got.cnt);
            $display("vld %0b/%0b last %0b/%0b (expected/actual)",
                     want.vld, got.vld, want.lst, got.lst);
          end
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("[%0t] watchdog: no request moved for %0d cycles", $realtime, StallLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: reset, directed table, random searches, drain, verdict.
  initial begin
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] ln;
    logic       noisy;
    logic       want_tall;
    int         rand_sent;
    int         search_no;
    int         len;
    int         h;
    int         tgt;
    int         pick;

    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.sprite_y   = '0;
    in_ch.sprite_x   = '0;
    in_ch.scan_line  = '0;
    in_ch.last_entry = 1'b0;
    out_ch.ready     = 1'b0;
    send_idle_pct    = 36;
    recv_idle_pct    = 69;
    held_n           = 0;
    next_idx         = 0;
    tall_cfg         = 1'b0;
    err_count        = 0;
    idle_cycles      = 0;
    n_entries        = 0;
    n_results        = 0;
    n_searches       = 0;
    n_full           = 0;
    n_saturated      = 0;
    rand_sent        = 0;
    search_no        = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: rows change the height only where a search has just ended.
    for (int i = 0; i < 24; i++) begin
      if (dir_rows[i].tall !== tall_cfg) set_tall(dir_rows[i].tall);
      send_entry(dir_rows[i].y, dir_rows[i].x, dir_rows[i].ln, dir_rows[i].lst,
                 dir_rows[i].typed,
                 '{dir_rows[i].r_idx, dir_rows[i].r_x, dir_rows[i].r_cnt, dir_rows[i].r_vld,
                   1'b1});
    end

    // Random part: mostly well-formed searches on one line with entries aimed at the window,
    // plus overlong searches that run past the table end and a few with a ragged line.
    while (rand_sent < ItemGoal) begin
      if (rand_sent < ItemGoal / 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 69;
      end else if (rand_sent < 2 * ItemGoal / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      want_tall = ((search_no / 3) % 2) == 0;
      if (want_tall !== tall_cfg) set_tall(want_tall);
      else if (search_no == 4) wait_idle();

      pick = $urandom_range(0, 7);
      if (pick == 0) len = $urandom_range(TableEntriesDef + 1, TableEntriesDef + 6);
      else if (pick <= 2) len = TableEntriesDef;
      else len = $urandom_range(1, TableEntriesDef);
      noisy = ($urandom_range(0, 9) == 0);
      ln    = 8'($urandom_range(0, 153));
      h     = tall_cfg ? TallHeight : ShortHeight;

      for (int e = 0; e < len; e++) begin
        if (noisy) ln = 8'($urandom_range(0, 153));
        tgt  = int'(ln) + YOffset;
        pick = $urandom_range(0, 9);
        if (pick <= 4) y = 8'(tgt - $urandom_range(0, h - 1));
        else if (pick == 5) y = 8'(tgt + 1);
        else if (pick == 6) y = 8'(tgt - h);
        else y = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0) x = 8'($urandom_range(0, 3));
        else x = 8'($urandom_range(0, 255));
        send_entry(y, x, ln, (e == len - 1), 1'b0, '0);
      end
      rand_sent += len;
      search_no++;
    end

    // Drain: the watchdog bounds this wait, then let the pipeline settle.
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d entry requests in %0d searches, %0d results checked;",
             n_entries, n_searches, n_results);
    $display("%0d searches filled the list, %0d entries fell past the table end, %0d errors.",
             n_full, n_saturated, err_count);
    if (err_count == 0 && pending_hits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
